// File: rtl/core/twelve_hour_clock_with_touch_set_top_macros.svh
// ----------------------------------------------------------------------------
// Twelve-hour clock assertion macros
// Short forms for the concurrent checks used in the clock core.
// ----------------------------------------------------------------------------
`ifndef TWELVE_HOUR_CLOCK_WITH_TOUCH_SET_TOP_MACROS_SVH
`define TWELVE_HOUR_CLOCK_WITH_TOUCH_SET_TOP_MACROS_SVH

// Holds on every clock edge outside reset.
`define THC_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent holds on the same edge as the antecedent.
`define THC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds on the edge after the antecedent.
`define THC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/thc_pkg.sv
// ----------------------------------------------------------------------------
// Twelve-hour clock package
// Shared types, codes, constants and digit helpers for the clock core.
// ----------------------------------------------------------------------------
`default_nettype none

package thc_pkg;

  localparam int unsigned FieldW = 6;
  localparam int unsigned HourW  = 4;
  localparam int unsigned CoordW = 10;
  localparam int unsigned TextW  = 64;
  localparam int unsigned Chars  = 8;

  localparam logic [FieldW-1:0] SEC_MIN  = 6'd0;
  localparam logic [FieldW-1:0] SEC_MAX  = 6'd59;
  localparam logic [FieldW-1:0] HOUR_MIN = 6'd1;
  localparam logic [FieldW-1:0] HOUR_MAX = 6'd12;

  localparam logic [CoordW-1:0] UPPER_Y_RESET  = 10'd120;
  localparam logic [CoordW-1:0] LEFT_X_RESET   = 10'd106;
  localparam logic [CoordW-1:0] MIDDLE_X_RESET = 10'd212;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_TOUCH  = 2'd1,
    FUNC_REDRAW = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_UPPER_Y  = 2'd0,
    REG_LEFT_X   = 2'd1,
    REG_MIDDLE_X = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic up;
    logic down;
  } step_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } digits_t;

  typedef struct packed {
    logic [HourW-1:0]  hours;
    logic [FieldW-1:0] minutes;
    logic [FieldW-1:0] seconds;
    logic [TextW-1:0]  text;
    logic [Chars-1:0]  mask;
  } result_t;

  function automatic digits_t split_digits(input logic [FieldW-1:0] v);
    digits_t d;
    logic [FieldW-1:0] rest;
    if (v >= 6'd50) begin
      d.tens = 3'd5;
    end else if (v >= 6'd40) begin
      d.tens = 3'd4;
    end else if (v >= 6'd30) begin
      d.tens = 3'd3;
    end else if (v >= 6'd20) begin
      d.tens = 3'd2;
    end else if (v >= 6'd10) begin
      d.tens = 3'd1;
    end else begin
      d.tens = 3'd0;
    end
    rest = v - FieldW'({3'd0, d.tens} * 6'd10);
    d.ones = rest[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/thc_cell.sv
// ----------------------------------------------------------------------------
// Twelve-hour clock field cell
// One wrapping time field that steps up or down and passes its carry on.
// ----------------------------------------------------------------------------
`default_nettype none

module thc_cell
  import thc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire step_t             step,
  input  wire logic [FieldW-1:0] lo,
  input  wire logic [FieldW-1:0] hi,
  input  wire logic [FieldW-1:0] init,
  output logic      [FieldW-1:0] value,
  output logic      [FieldW-1:0] value_next,
  output logic                   carry
);

  always_comb begin
    value_next = value;
    if (step.up) begin
      value_next = (value == hi) ? lo : value + 6'd1;
    end else if (step.down) begin
      value_next = (value == lo) ? hi : value - 6'd1;
    end
  end

  assign carry = step.up && (value == hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= init;
    end else begin
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/thc_text.sv
// ----------------------------------------------------------------------------
// Twelve-hour clock text formatter
// Builds the eight-character hh:mm:ss text with a space-padded hour.
// ----------------------------------------------------------------------------
`default_nettype none

module thc_text
  import thc_pkg::*;
(
  input  wire logic [FieldW-1:0] hours,
  input  wire logic [FieldW-1:0] minutes,
  input  wire logic [FieldW-1:0] seconds,
  output logic      [TextW-1:0]  text
);

  digits_t hd, md, sd;

  always_comb begin
    hd = split_digits(hours);
    md = split_digits(minutes);
    sd = split_digits(seconds);
    text[7:0]   = (hd.tens != 3'd0) ? CHAR_ZERO + {5'd0, hd.tens} : CHAR_SPACE;
    text[15:8]  = CHAR_ZERO + {4'd0, hd.ones};
    text[23:16] = CHAR_COLON;
    text[31:24] = CHAR_ZERO + {5'd0, md.tens};
    text[39:32] = CHAR_ZERO + {4'd0, md.ones};
    text[47:40] = CHAR_COLON;
    text[55:48] = CHAR_ZERO + {5'd0, sd.tens};
    text[63:56] = CHAR_ZERO + {4'd0, sd.ones};
  end

endmodule

`default_nettype wire

// File: rtl/core/twelve_hour_clock_with_touch_set_top.sv
// ----------------------------------------------------------------------------
// Twelve-hour clock with touch set, top level
// An accepted item's result is registered in the output entry, or in the skid
// entry of the two-entry buffer while the output entry is held. Throughput: one
// item per cycle while the skid entry is empty; the carry chain is combinational.
// Reset: time returns to 12:59:59, shown text clears, thresholds reload.
// ----------------------------------------------------------------------------
`default_nettype none

`include "twelve_hour_clock_with_touch_set_top_macros.svh"

module twelve_hour_clock_with_touch_set_top
  import thc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire logic [1:0]        func,
  input  wire logic [CoordW-1:0] touch_x,
  input  wire logic [CoordW-1:0] touch_y,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output logic [HourW-1:0]       hours,
  output logic [FieldW-1:0]      minutes,
  output logic [FieldW-1:0]      seconds,
  output logic [TextW-1:0]       time_text,
  output logic [Chars-1:0]       redraw_mask,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CoordW-1:0] cfg_data
);

  logic [CoordW-1:0] upper_y, left_x, middle_x;
  logic [TextW-1:0]  shown;
  logic              skid_valid;
  result_t           out_q, skid_q, res_new;

  logic              accept, take, is_tick, is_touch, force_all, touch_up;
  logic              pick_hour, pick_min;
  step_t             sec_step, min_step, hr_step;
  logic [FieldW-1:0] sec_val, min_val, hr_val;
  logic [FieldW-1:0] sec_next, min_next, hr_next;
  logic              sec_carry, min_carry, hr_carry;
  logic [TextW-1:0]  text_new;
  logic [Chars-1:0]  mask_new;

  assign cfg_ready  = 1'b1;
  assign item_ready = !skid_valid;
  assign accept     = item_valid && item_ready;
  assign take       = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_y  <= UPPER_Y_RESET;
      left_x   <= LEFT_X_RESET;
      middle_x <= MIDDLE_X_RESET;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_UPPER_Y:  upper_y  <= cfg_data;
        REG_LEFT_X:   left_x   <= cfg_data;
        REG_MIDDLE_X: middle_x <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_tick   = 1'b0;
    is_touch  = 1'b0;
    force_all = 1'b0;
    case (func_t'(func))
      FUNC_TICK:   is_tick   = accept;
      FUNC_TOUCH:  is_touch  = accept;
      FUNC_REDRAW: force_all = 1'b1;
      default: ;
    endcase
    touch_up  = touch_y < upper_y;
    pick_hour = touch_x <= left_x;
    pick_min  = !pick_hour && (touch_x <= middle_x);

    sec_step.up   = is_tick || (is_touch && !pick_hour && !pick_min && touch_up);
    sec_step.down = is_touch && !pick_hour && !pick_min && !touch_up;
    min_step.up   = (is_tick && sec_carry) || (is_touch && pick_min && touch_up);
    min_step.down = is_touch && pick_min && !touch_up;
    hr_step.up    = (is_tick && sec_carry && min_carry) || (is_touch && pick_hour && touch_up);
    hr_step.down  = is_touch && pick_hour && !touch_up;
  end

  thc_cell u_sec (
    .clk(clk), .rst(rst), .step(sec_step), .lo(SEC_MIN), .hi(SEC_MAX), .init(SEC_MAX),
    .value(sec_val), .value_next(sec_next), .carry(sec_carry)
  );

  thc_cell u_min (
    .clk(clk), .rst(rst), .step(min_step), .lo(SEC_MIN), .hi(SEC_MAX), .init(SEC_MAX),
    .value(min_val), .value_next(min_next), .carry(min_carry)
  );

  thc_cell u_hour (
    .clk(clk), .rst(rst), .step(hr_step), .lo(HOUR_MIN), .hi(HOUR_MAX), .init(HOUR_MAX),
    .value(hr_val), .value_next(hr_next), .carry(hr_carry)
  );

  thc_text u_text (
    .hours(hr_next), .minutes(min_next), .seconds(sec_next), .text(text_new)
  );

  always_comb begin
    for (int i = 0; i < Chars; i++) begin
      mask_new[i] = force_all || (text_new[8*i +: 8] != shown[8*i +: 8]);
    end
    res_new.hours   = hr_next[HourW-1:0];
    res_new.minutes = min_next;
    res_new.seconds = sec_next;
    res_new.text    = text_new;
    res_new.mask    = mask_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown <= '0;
    end else if (accept) begin
      shown <= text_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take || !result_valid) begin
      result_valid <= skid_valid || accept;
      skid_valid   <= skid_valid && accept;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !result_valid) begin
      if (skid_valid) begin
        out_q <= skid_q;
        if (accept) begin
          skid_q <= res_new;
        end
      end else if (accept) begin
        out_q <= res_new;
      end
    end else if (accept) begin
      skid_q <= res_new;
    end
  end

  assign hours       = out_q.hours;
  assign minutes     = out_q.minutes;
  assign seconds     = out_q.seconds;
  assign time_text   = out_q.text;
  assign redraw_mask = out_q.mask;

  `THC_ASSERT_SAME(a_skid_behind_out, skid_valid, result_valid, "Skid entry without an output entry.")
  `THC_ASSERT(a_hour_range, hr_val >= HOUR_MIN && hr_val <= HOUR_MAX, "Hour out of range.")
  `THC_ASSERT_SAME(a_latest_shown, result_valid && !skid_valid, out_q.text == shown, "Newest result text differs from shown text.")
  `THC_ASSERT_NEXT(a_no_stray_carry, accept && func == FUNC_TICK && sec_val != SEC_MAX, $stable(min_val), "Minutes moved without a seconds carry.")
  `THC_ASSERT_SAME(a_hour_wrap, hr_carry, hr_next == HOUR_MIN, "Hour wrap did not return to one.")

endmodule

`default_nettype wire
